// ===== rtl/utrb_pkg.sv =====
// UART transmit/receive ring buffer package: modes, ring control types, default depths.
// No dependencies.
`timescale 1ns / 1ps

package utrb_pkg;

   localparam int TX_DEPTH_DEF = 64;
   localparam int RX_DEPTH_DEF = 64;

   typedef enum logic [1:0] {
      MODE_PUT  = 2'd0,
      MODE_GET  = 2'd1,
      MODE_RECV = 2'd2,
      MODE_THRE = 2'd3
   } mode_type;

   typedef struct packed {
      logic push;
      logic pop;
   } ring_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } ring_status_type;

endpackage

// ===== rtl/uart_tx_rx_ring_buffers_unit.sv =====
// UART transmit/receive ring buffers: top level, decodes modes and drives two rings.
// The result strobes in the cycle after start is taken; one transaction per cycle.
// busy stays low; the pop read of the ring memory is registered.
// Reset (synchronous) clears pointers, full flags, overflow and interrupt enable;
// ring contents are not cleared. The receiver cannot stall results.
// Depends on utrb_pkg and utrb_ring.
`timescale 1ns / 1ps

module uart_tx_rx_ring_buffers_unit
   import utrb_pkg::*;
#(
   parameter int TX_DEPTH = TX_DEPTH_DEF,
   parameter int RX_DEPTH = RX_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_mode,
   input  logic [7:0] req_data,
   input  logic       req_line_idle,
   output logic       rsp_valid,
   output logic       rsp_tx_valid,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_rx_valid,
   output logic [7:0] rsp_rx_byte,
   output logic       rsp_put_refused,
   output logic       rsp_overflow_seen,
   output logic       rsp_tx_irq_enable
);

   mode_type        mode;
   logic            accept;
   ring_cmd_type    tx_cmd, rx_cmd;
   ring_status_type tx_st, rx_st;
   logic [7:0]      tx_pop_data, rx_pop_data;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       tx_valid_ff, tx_valid_in;
   logic       direct_ff, direct_in;
   logic [7:0] direct_byte_ff;
   logic       rx_valid_ff, rx_valid_in;
   logic       refused_ff, refused_in;
   logic       ovf_ff, ovf_in;
   logic       irq_ff, irq_in;

   assign busy   = 1'b0;
   assign accept = start;
   assign mode   = mode_type'(req_mode);

   always_comb begin
      tx_cmd       = '0;
      rx_cmd       = '0;
      tx_valid_in  = 1'b0;
      direct_in    = 1'b0;
      rx_valid_in  = 1'b0;
      refused_in   = 1'b0;
      ovf_in       = ovf_ff;
      irq_in       = irq_ff;
      rsp_valid_in = accept;
      if (accept) begin
         unique case (mode)
            MODE_PUT: begin
               if (req_line_idle && tx_st.empty) begin
                  tx_valid_in = 1'b1;
                  direct_in   = 1'b1;
               end else if (tx_st.full) begin
                  refused_in = 1'b1;
               end else begin
                  tx_cmd.push = 1'b1;
                  irq_in      = 1'b1;
               end
            end
            MODE_GET: begin
               if (!rx_st.empty) begin
                  rx_cmd.pop  = 1'b1;
                  rx_valid_in = 1'b1;
               end
            end
            MODE_RECV: begin
               if (rx_st.full) begin
                  ovf_in = 1'b1;
               end else begin
                  rx_cmd.push = 1'b1;
               end
            end
            MODE_THRE: begin
               if (!tx_st.empty) begin
                  tx_cmd.pop  = 1'b1;
                  tx_valid_in = 1'b1;
               end else begin
                  irq_in = 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         tx_valid_ff  <= 1'b0;
         direct_ff    <= 1'b0;
         rx_valid_ff  <= 1'b0;
         refused_ff   <= 1'b0;
         ovf_ff       <= 1'b0;
         irq_ff       <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         tx_valid_ff  <= tx_valid_in;
         direct_ff    <= direct_in;
         rx_valid_ff  <= rx_valid_in;
         refused_ff   <= refused_in;
         ovf_ff       <= ovf_in;
         irq_ff       <= irq_in;
      end
   end

   always_ff @(posedge clock) begin
      direct_byte_ff <= req_data;
   end

   utrb_ring #(.DEPTH(TX_DEPTH)) u_tx_ring (
      .clock     (clock),
      .reset     (reset),
      .cmd       (tx_cmd),
      .push_data (req_data),
      .status    (tx_st),
      .pop_data  (tx_pop_data)
   );

   utrb_ring #(.DEPTH(RX_DEPTH)) u_rx_ring (
      .clock     (clock),
      .reset     (reset),
      .cmd       (rx_cmd),
      .push_data (req_data),
      .status    (rx_st),
      .pop_data  (rx_pop_data)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_tx_valid      = tx_valid_ff;
   assign rsp_tx_byte       = !tx_valid_ff ? 8'h00 : (direct_ff ? direct_byte_ff : tx_pop_data);
   assign rsp_rx_valid      = rx_valid_ff;
   assign rsp_rx_byte       = rx_valid_ff ? rx_pop_data : 8'h00;
   assign rsp_put_refused   = refused_ff;
   assign rsp_overflow_seen = ovf_ff;
   assign rsp_tx_irq_enable = irq_ff;

`ifndef SYNTH
   a_ovf_sticky: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |=> ovf_ff)
      else $error("overflow flag cleared without reset");
   a_one_action: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $countones({tx_valid_ff, rx_valid_ff, refused_ff}) <= 1)
      else $error("more than one action reported for one transaction");
   a_quiet_idle: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> !(tx_valid_ff || rx_valid_ff || refused_ff || direct_ff))
      else $error("action reported without a transaction");
`endif

endmodule

// ===== rtl/utrb_ring.sv =====
// Byte ring buffer: synchronous memory with head/tail pointers and full flag.
// Depends on utrb_pkg.
`timescale 1ns / 1ps

module utrb_ring
   import utrb_pkg::*;
#(
   parameter int DEPTH = TX_DEPTH_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  ring_cmd_type    cmd,
   input  logic [7:0]      push_data,
   output ring_status_type status,
   output logic [7:0]      pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   logic [7:0]       mem [DEPTH];
   logic [7:0]       rd_ff;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic             full_ff, full_in;
   logic [PTR_W-1:0] head_next;
   logic [PTR_W-1:0] tail_next;

   assign head_next = (head_ff == LAST_PTR) ? '0 : head_ff + 1'b1;
   assign tail_next = (tail_ff == LAST_PTR) ? '0 : tail_ff + 1'b1;

   assign status.empty = (head_ff == tail_ff) && !full_ff;
   assign status.full  = full_ff;
   assign pop_data     = rd_ff;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      full_in = full_ff;
      if (cmd.push) begin
         head_in = head_next;
         full_in = (head_next == tail_ff);
      end
      if (cmd.pop) begin
         tail_in = tail_next;
         full_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         full_ff <= 1'b0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         full_ff <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[head_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pop) begin
         rd_ff <= mem[tail_ff];
      end
   end

`ifndef SYNTH
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> !full_ff)
      else $error("push into full ring");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> !status.empty)
      else $error("pop from empty ring");
   a_full_ptrs: assert property (@(posedge clock) disable iff (reset)
      (cmd.push && !cmd.pop && head_next == tail_ff) |=> full_ff)
      else $error("ring did not go full when head caught tail");
`endif

endmodule

// ===== tb/sv/uart_tx_rx_ring_buffers_unit_test.sv =====
// Testbench for uart_tx_rx_ring_buffers_unit: directed table, then biased random bursts
// that fill, drain and wrap both rings, checked against a behavioral ring predictor.
// Depends on utrb_pkg and the unit RTL.
`timescale 1ns / 1ps

module uart_tx_rx_ring_buffers_unit_test
   import utrb_pkg::*;
();

   localparam int RANDOM_ITEMS = 950;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int MAX_REPORTS  = 40;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic       put_refused;
      logic       overflow_seen;
      logic       tx_irq_enable;
   } ring_outcome_type;

   typedef struct packed {
      mode_type         mode;
      logic [7:0]       data;
      logic             line_idle;
      logic             typed;
      ring_outcome_type outcome;
   } stim_row_type;

   typedef enum int {TX_FILL, TX_DRAIN, RX_FILL, RX_DRAIN, MIXED} burst_kind_type;

   localparam ring_outcome_type QUIET       = '0;
   localparam ring_outcome_type SENT_FF     = '{1'b1, 8'hFF, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0};
   localparam ring_outcome_type QUEUED      = '{1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1};
   localparam ring_outcome_type SENT_00_IRQ = '{1'b1, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1};
   localparam ring_outcome_type GOT_FF      = '{1'b0, 8'h00, 1'b1, 8'hFF, 1'b0, 1'b0, 1'b0};

   localparam int NUM_ROWS = 20;

   stim_row_type directed_rows [NUM_ROWS] = '{
      '{MODE_GET,  8'h00, 1'b0, 1'b1, QUIET},
      '{MODE_THRE, 8'h00, 1'b1, 1'b1, QUIET},
      '{MODE_PUT,  8'hFF, 1'b1, 1'b1, SENT_FF},
      '{MODE_PUT,  8'h00, 1'b0, 1'b1, QUEUED},
      '{MODE_PUT,  8'hA5, 1'b1, 1'b0, QUIET},
      '{MODE_PUT,  8'h5A, 1'b0, 1'b0, QUIET},
      '{MODE_THRE, 8'hFF, 1'b0, 1'b1, SENT_00_IRQ},
      '{MODE_THRE, 8'h00, 1'b1, 1'b0, QUIET},
      '{MODE_THRE, 8'h00, 1'b0, 1'b0, QUIET},
      '{MODE_THRE, 8'h00, 1'b0, 1'b1, QUIET},
      '{MODE_THRE, 8'hFF, 1'b1, 1'b0, QUIET},
      '{MODE_RECV, 8'hFF, 1'b1, 1'b1, QUIET},
      '{MODE_RECV, 8'h00, 1'b0, 1'b0, QUIET},
      '{MODE_RECV, 8'h81, 1'b1, 1'b0, QUIET},
      '{MODE_GET,  8'h00, 1'b0, 1'b1, GOT_FF},
      '{MODE_GET,  8'hFF, 1'b1, 1'b0, QUIET},
      '{MODE_GET,  8'h00, 1'b0, 1'b0, QUIET},
      '{MODE_GET,  8'h00, 1'b1, 1'b1, QUIET},
      '{MODE_PUT,  8'h7E, 1'b1, 1'b0, QUIET},
      '{MODE_GET,  8'hFF, 1'b1, 1'b0, QUIET}
   };

   logic             clock;
   logic             reset         = 1'b1;
   logic             start         = 1'b0;
   mode_type         req_mode      = MODE_PUT;
   logic [7:0]       req_data      = 8'h00;
   logic             req_line_idle = 1'b0;
   logic             busy;
   logic             rsp_valid;
   logic             rsp_tx_valid;
   logic [7:0]       rsp_tx_byte;
   logic             rsp_rx_valid;
   logic [7:0]       rsp_rx_byte;
   logic             rsp_put_refused;
   logic             rsp_overflow_seen;
   logic             rsp_tx_irq_enable;

   logic             row_typed = 1'b0;
   ring_outcome_type row_fixed = '0;
   int               idle_pct  = 0;
   int               errors    = 0;
   int               cycle_count = 0;
   ring_outcome_type outcome_q [$];

   // predictor state
   logic [7:0] tx_mem [TX_DEPTH_DEF];
   logic [7:0] rx_mem [RX_DEPTH_DEF];
   int         tx_wr = 0, tx_rd = 0, rx_wr = 0, rx_rd = 0;
   logic       tx_full = 1'b0, rx_full = 1'b0, rx_overrun = 1'b0, tx_irq = 1'b0;

   uart_tx_rx_ring_buffers_unit dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_data          (req_data),
      .req_line_idle     (req_line_idle),
      .rsp_valid         (rsp_valid),
      .rsp_tx_valid      (rsp_tx_valid),
      .rsp_tx_byte       (rsp_tx_byte),
      .rsp_rx_valid      (rsp_rx_valid),
      .rsp_rx_byte       (rsp_rx_byte),
      .rsp_put_refused   (rsp_put_refused),
      .rsp_overflow_seen (rsp_overflow_seen),
      .rsp_tx_irq_enable (rsp_tx_irq_enable)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int next_slot(int p, int depth);
      return (p + 1 >= depth) ? 0 : p + 1;
   endfunction

   function automatic ring_outcome_type apply_ring_op(mode_type m, logic [7:0] d, logic li);
      ring_outcome_type o;
      logic tx_empty, rx_empty;
      o = '0;
      tx_empty = (tx_wr == tx_rd) && !tx_full;
      rx_empty = (rx_wr == rx_rd) && !rx_full;
      case (m)
         MODE_PUT: begin
            if (li && tx_empty) begin
               o.tx_valid = 1'b1;
               o.tx_byte  = d;
            end else if (tx_full) begin
               o.put_refused = 1'b1;
            end else begin
               tx_mem[tx_wr] = d;
               tx_wr = next_slot(tx_wr, TX_DEPTH_DEF);
               if (tx_wr == tx_rd) tx_full = 1'b1;
               tx_irq = 1'b1;
            end
         end
         MODE_GET: begin
            if (!rx_empty) begin
               o.rx_valid = 1'b1;
               o.rx_byte  = rx_mem[rx_rd];
               rx_rd = next_slot(rx_rd, RX_DEPTH_DEF);
               rx_full = 1'b0;
            end
         end
         MODE_RECV: begin
            if (rx_full) begin
               rx_overrun = 1'b1;
            end else begin
               rx_mem[rx_wr] = d;
               rx_wr = next_slot(rx_wr, RX_DEPTH_DEF);
               if (rx_wr == rx_rd) rx_full = 1'b1;
            end
         end
         default: begin
            if (!tx_empty) begin
               o.tx_valid = 1'b1;
               o.tx_byte  = tx_mem[tx_rd];
               tx_rd = next_slot(tx_rd, TX_DEPTH_DEF);
               tx_full = 1'b0;
            end else begin
               tx_irq = 1'b0;
            end
         end
      endcase
      o.overflow_seen = rx_overrun;
      o.tx_irq_enable = tx_irq;
      return o;
   endfunction

   task automatic flag_field(string name, logic [7:0] want, logic [7:0] got);
      errors++;
      if (errors <= MAX_REPORTS)
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
   endtask

   task automatic drive_item(mode_type m, logic [7:0] d, logic li, logic typed,
                             ring_outcome_type fixed);
      @(negedge clock);
      while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start         <= 1'b1;
      req_mode      <= m;
      req_data      <= d;
      req_line_idle <= li;
      row_typed     <= typed;
      row_fixed     <= fixed;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   always @(posedge clock) begin : check_rsp
      ring_outcome_type want;
      ring_outcome_type got;
      if (!reset) begin
         if (rsp_valid) begin
            got = '{rsp_tx_valid, rsp_tx_byte, rsp_rx_valid, rsp_rx_byte,
                    rsp_put_refused, rsp_overflow_seen, rsp_tx_irq_enable};
            if (outcome_q.size() == 0) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("%0t: result with no transaction outstanding, expected none, actual %0h",
                           $time, got);
            end else begin
               want = outcome_q.pop_front();
               if (got.tx_valid !== want.tx_valid)
                  flag_field("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
               if (got.tx_byte !== want.tx_byte)
                  flag_field("tx_byte", want.tx_byte, got.tx_byte);
               if (got.rx_valid !== want.rx_valid)
                  flag_field("rx_valid", 8'(want.rx_valid), 8'(got.rx_valid));
               if (got.rx_byte !== want.rx_byte)
                  flag_field("rx_byte", want.rx_byte, got.rx_byte);
               if (got.put_refused !== want.put_refused)
                  flag_field("put_refused", 8'(want.put_refused), 8'(got.put_refused));
               if (got.overflow_seen !== want.overflow_seen)
                  flag_field("overflow_seen", 8'(want.overflow_seen), 8'(got.overflow_seen));
               if (got.tx_irq_enable !== want.tx_irq_enable)
                  flag_field("tx_irq_enable", 8'(want.tx_irq_enable), 8'(got.tx_irq_enable));
            end
         end
         if (start && !busy) begin
            want = apply_ring_op(req_mode, req_data, req_line_idle);
            outcome_q.push_back(row_typed ? row_fixed : want);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin : stimulus
      int             sent;
      int             burst;
      int             len;
      int             bias;
      burst_kind_type kind;
      mode_type       m;
      int             idle_phases [3];
      idle_phases = '{0, 49, 17};
      sent  = 0;
      burst = 0;

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         drive_item(directed_rows[i].mode, directed_rows[i].data, directed_rows[i].line_idle,
                    directed_rows[i].typed, directed_rows[i].outcome);

      // first four bursts fill and drain each ring past full, wrapping pointers
      while (sent < RANDOM_ITEMS) begin
         if (burst < 4) begin
            kind = burst_kind_type'(burst);
            len  = 70;
            bias = 100;
         end else begin
            kind = burst_kind_type'($urandom_range(0, 4));
            len  = $urandom_range(5, 80);
            bias = 85;
         end
         idle_pct = idle_phases[burst % 3];
         for (int n = 0; n < len && sent < RANDOM_ITEMS; n++) begin
            m = mode_type'($urandom_range(0, 3));
            if ($urandom_range(0, 99) < bias) begin
               case (kind)
                  TX_FILL:  m = MODE_PUT;
                  TX_DRAIN: m = MODE_THRE;
                  RX_FILL:  m = MODE_RECV;
                  RX_DRAIN: m = MODE_GET;
                  default:  ;
               endcase
            end
            drive_item(m, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0);
            sent++;
         end
         burst++;
      end

      @(negedge clock);
      start <= 1'b0;
      while (outcome_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
